>>> rtl/lfp_pkg.sv
// Package for the nine-byte rangefinder frame parser.
// Holds the frame constants and field widths; it depends on nothing.
package lfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned POS_W = 4;
  localparam int unsigned PAYLOAD_DEPTH = 4;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h59;

  localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
  localparam logic [POS_W-1:0] POS_HEADER2 = 4'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = 4'd2;
  localparam logic [POS_W-1:0] POS_PAYLOAD_LAST = 4'd5;
  localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd8;

endpackage

>>> rtl/lfp_in_if.sv
// Input channel of the frame parser: one received serial byte per word.
// Depends on lfp_pkg for the byte width.
interface lfp_in_if import lfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/lfp_out_if.sv
// Result channel of the frame parser: one word per completed frame.
// Depends on lfp_pkg for the value widths.
interface lfp_out_if import lfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               checksum_good;
  logic [VALUE_W-1:0] distance_cm;
  logic [VALUE_W-1:0] signal_strength;

  modport source (output valid, output checksum_good, output distance_cm,
                  output signal_strength, input ready);
  modport sink (input valid, input checksum_good, input distance_cm,
                input signal_strength, output ready);
endinterface

>>> rtl/lidar_frame_parser_core.sv
// Nine-byte rangefinder frame parser: position counter, running sum,
// payload bytes, held values and a registered result word.
// Depends on lfp_pkg, lfp_in_if and lfp_out_if.
// The result word is registered: it is valid in the cycle after the checksum byte is taken.
// Throughput: one byte per cycle; a byte is refused only when it is a checksum
// byte and the previous result word still waits in the output register.
// Reset (rst_n, synchronous, active low) returns the parser to header hunting
// and clears the running sum, the held values and the output valid.
module lidar_frame_parser_core import lfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lfp_in_if.sink    in_rx,
  lfp_out_if.source out_res
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  payload_r [PAYLOAD_DEPTH];
  logic [VALUE_W-1:0] held_dist_r, held_dist_nxt;
  logic [VALUE_W-1:0] held_str_r, held_str_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_good_r;
  logic [VALUE_W-1:0] out_dist_r, out_str_r;

  logic [POS_W-1:0]   pos_eff;
  logic               accept;
  logic               is_header;
  logic               good;
  logic               payload_we;
  logic [1:0]         payload_idx;

  assign pos_eff = (pos_r > POS_CHECKSUM) ? POS_HUNT : pos_r;
  assign in_rx.ready = !out_valid_r || out_res.ready || (pos_eff != POS_CHECKSUM);
  assign accept = in_rx.valid && in_rx.ready;
  assign is_header = (in_rx.rx_byte == HEADER_BYTE);
  assign good = (in_rx.rx_byte == sum_r);
  assign payload_we = accept && (pos_eff >= POS_PAYLOAD_FIRST) &&
                      (pos_eff <= POS_PAYLOAD_LAST);
  assign payload_idx = 2'(pos_eff - POS_PAYLOAD_FIRST);

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    held_dist_nxt = held_dist_r;
    held_str_nxt = held_str_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    if (accept) begin
      case (pos_eff)
        POS_HUNT: begin
          if (is_header) begin
            sum_nxt = in_rx.rx_byte;
            pos_nxt = POS_HEADER2;
          end else begin
            pos_nxt = POS_HUNT;
          end
        end
        POS_HEADER2: begin
          if (is_header) begin
            sum_nxt = sum_r + in_rx.rx_byte;
            pos_nxt = POS_PAYLOAD_FIRST;
          end else begin
            pos_nxt = POS_HUNT;
          end
        end
        POS_CHECKSUM: begin
          if (good) begin
            held_dist_nxt = {payload_r[1], payload_r[0]};
            held_str_nxt = {payload_r[3], payload_r[2]};
          end
          pos_nxt = POS_HUNT;
          sum_nxt = '0;
          out_valid_nxt = 1'b1;
        end
        default: begin
          sum_nxt = sum_r + in_rx.rx_byte;
          pos_nxt = pos_eff + 4'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      sum_r <= '0;
      held_dist_r <= '0;
      held_str_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      held_dist_r <= held_dist_nxt;
      held_str_r <= held_str_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (payload_we) begin
      payload_r[payload_idx] <= in_rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_eff == POS_CHECKSUM)) begin
      out_good_r <= good;
      out_dist_r <= held_dist_nxt;
      out_str_r <= held_str_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.checksum_good = out_good_r;
  assign out_res.distance_cm = out_dist_r;
  assign out_res.signal_strength = out_str_r;

endmodule
